// File: hdl/sdd_pkg.sv
// Shared constants for the shuffled deck dealer.
package sdd_pkg;

	localparam int CARD_W = 6;
	localparam int RANK_W = 4;
	localparam int SUIT_W = 2;
	localparam int REM_W  = 6;
	localparam int ENT_W  = 32;
	localparam int SEED_W = 32;
	localparam int DRAW_W = 16;

	localparam logic [SEED_W-1:0] LCG_MUL    = 32'd1664525;
	localparam logic [SEED_W-1:0] LCG_ADD    = 32'd1013904223;
	localparam logic [SEED_W-1:0] SEED_RESET = 32'h04B1465C;
	localparam logic [SEED_W-1:0] MIX_CONST  = 32'hC0FFEE11;

	localparam logic CMD_DEAL    = 1'b0;
	localparam logic CMD_SHUFFLE = 1'b1;

endpackage

// File: hdl/sdd_mod.sv
// Bit-serial remainder unit: num mod den, one dividend bit per cycle.
module sdd_mod #(
	parameter int DIV_W = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sdd_pkg::DRAW_W-1:0] num,
	input  logic [DIV_W-1:0]          den,
	output logic                      done,
	output logic [DIV_W-1:0]          rem
);
	import sdd_pkg::*;

	localparam int STEP_W = $clog2(DRAW_W);

	logic [DRAW_W-1:0] num_q;
	logic [DIV_W-1:0]  den_q;
	logic [DIV_W-1:0]  rem_q;
	logic [STEP_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;
	logic              take;

	always_comb begin
		trial = {rem_q, num_q[DRAW_W-1]};
		take  = (trial >= {1'b0, den_q});
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q <= num;
				den_q <= den;
				rem_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				num_q <= num_q << 1;
				rem_q <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(DRAW_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: hdl/shuffled_deck_dealer.sv
// Top level of the shuffled deck dealer: shoe memory, generator and sequencer.
//
// Usage: raise start with cmd and entropy while busy is low; the item is
// taken at that clock edge. cmd deal pops the top card of the shoe; cmd
// reshuffle mixes entropy into the seed, loads the shoe in order, shuffles
// it and deals the first card. Each item gives one result on card, rank,
// suit, remaining and empty_res, shown for one cycle with done high. There
// is no back pressure: the result must be taken in that cycle.
// A deal from an empty shoe registers its result on acceptance; a deal
// reads the shoe on acceptance and registers the card in ST_DEAL.
// A reshuffle fills DECK_SIZE cards in ST_FILL, then runs DECK_SIZE-1 swap
// steps (ST_LCG, ST_DRAW, ST_WAIT on the serial remainder unit, ST_SWAP_RD,
// ST_WR_I, ST_WR_J), then ST_FIRST and ST_DEAL. busy stays high meanwhile.
// A new item may be accepted in the cycle the previous result is shown.
// Reset sets the seed to its start value and empties the shoe; a deal
// before the first reshuffle reports an empty shoe.
module shuffled_deck_dealer #(
	parameter int DECK_SIZE = 52,
	parameter int RANKS     = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       cmd,
	input  logic [sdd_pkg::ENT_W-1:0]  entropy,
	output logic                       done,
	output logic [sdd_pkg::CARD_W-1:0] card,
	output logic [sdd_pkg::RANK_W-1:0] rank,
	output logic [sdd_pkg::SUIT_W-1:0] suit,
	output logic [sdd_pkg::REM_W-1:0]  remaining,
	output logic                       empty_res
);
	import sdd_pkg::*;

	localparam int IDX_W = $clog2(DECK_SIZE);
	localparam int CNT_W = $clog2(DECK_SIZE + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DEAL, ST_FILL, ST_LCG, ST_DRAW, ST_WAIT,
		ST_SWAP_RD, ST_WR_I, ST_WR_J, ST_FIRST
	} state_t;

	state_t             state_q;
	logic [SEED_W-1:0]  seed_q;
	logic [CNT_W-1:0]   cards_left_q;
	logic [IDX_W-1:0]   i_q;
	logic [IDX_W-1:0]   j_q;
	logic               done_q;
	logic [CARD_W-1:0]  card_q;
	logic [RANK_W-1:0]  rank_q;
	logic [SUIT_W-1:0]  suit_q;
	logic [REM_W-1:0]   remaining_q;
	logic               empty_q;

	logic [CARD_W-1:0]  shoe_mem [DECK_SIZE];
	logic [CARD_W-1:0]  rd_a_q;
	logic [CARD_W-1:0]  rd_b_q;

	logic [RANK_W-1:0]  rank_tbl [DECK_SIZE];
	logic [SUIT_W-1:0]  suit_tbl [DECK_SIZE];

	logic               accept;
	logic [CNT_W-1:0]   cl_dec;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_a_addr;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [CARD_W-1:0]  wr_data;
	logic               div_start;
	logic               div_done;
	logic [CNT_W-1:0]   div_rem;
	logic [CNT_W-1:0]   div_den;
	logic [SEED_W-1:0]  seed_next;
	logic [IDX_W-1:0]   top_idx;

	for (genvar g = 0; g < DECK_SIZE; g++) begin : g_tbl
		assign rank_tbl[g] = RANK_W'(g % RANKS);
		assign suit_tbl[g] = SUIT_W'(g / RANKS);
	end

	always_comb begin
		accept    = start && (state_q == ST_IDLE);
		cl_dec    = cards_left_q - CNT_W'(1);
		top_idx   = IDX_W'(DECK_SIZE - 1);
		rd_en     = (accept && cmd == CMD_DEAL && cards_left_q != '0)
			|| (state_q == ST_FIRST) || (state_q == ST_SWAP_RD);
		rd_a_addr = (state_q == ST_SWAP_RD) ? i_q : cl_dec[IDX_W-1:0];
		wr_en     = (state_q == ST_FILL) || (state_q == ST_WR_I) || (state_q == ST_WR_J);
		wr_addr   = (state_q == ST_WR_J) ? j_q : i_q;
		case (state_q)
			ST_FILL: wr_data = CARD_W'(i_q);
			ST_WR_I: wr_data = rd_b_q;
			default: wr_data = rd_a_q;
		endcase
		div_start = (state_q == ST_DRAW);
		div_den   = CNT_W'(i_q) + CNT_W'(1);
		seed_next = seed_q * LCG_MUL + LCG_ADD;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			shoe_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= shoe_mem[rd_a_addr];
			rd_b_q <= shoe_mem[j_q];
		end
	end

	sdd_mod #(
		.DIV_W(CNT_W)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (seed_q[SEED_W-1 -: DRAW_W]),
		.den   (div_den),
		.done  (div_done),
		.rem   (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seed_q       <= SEED_RESET;
			cards_left_q <= '0;
			i_q          <= '0;
			j_q          <= '0;
			done_q       <= 1'b0;
			card_q       <= '0;
			rank_q       <= '0;
			suit_q       <= '0;
			remaining_q  <= '0;
			empty_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_SHUFFLE) begin
							seed_q  <= seed_q ^ (entropy << 11) ^ MIX_CONST;
							i_q     <= '0;
							state_q <= ST_FILL;
						end else if (cards_left_q == '0) begin
							done_q      <= 1'b1;
							card_q      <= '0;
							rank_q      <= '0;
							suit_q      <= '0;
							remaining_q <= '0;
							empty_q     <= 1'b1;
						end else begin
							state_q <= ST_DEAL;
						end
					end
				end
				ST_FILL: begin
					if (i_q == top_idx) begin
						state_q <= ST_LCG;
					end else begin
						i_q <= i_q + IDX_W'(1);
					end
				end
				ST_LCG: begin
					seed_q  <= seed_next;
					state_q <= ST_DRAW;
				end
				ST_DRAW: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						j_q     <= div_rem[IDX_W-1:0];
						state_q <= ST_SWAP_RD;
					end
				end
				ST_SWAP_RD: begin
					state_q <= ST_WR_I;
				end
				ST_WR_I: begin
					state_q <= ST_WR_J;
				end
				ST_WR_J: begin
					if (i_q == IDX_W'(1)) begin
						cards_left_q <= CNT_W'(DECK_SIZE);
						state_q      <= ST_FIRST;
					end else begin
						i_q     <= i_q - IDX_W'(1);
						state_q <= ST_LCG;
					end
				end
				ST_FIRST: begin
					state_q <= ST_DEAL;
				end
				ST_DEAL: begin
					cards_left_q <= cl_dec;
					done_q       <= 1'b1;
					card_q       <= rd_a_q;
					rank_q       <= rank_tbl[rd_a_q[IDX_W-1:0]];
					suit_q       <= suit_tbl[rd_a_q[IDX_W-1:0]];
					remaining_q  <= REM_W'(cl_dec);
					empty_q      <= 1'b0;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign card      = card_q;
	assign rank      = rank_q;
	assign suit      = suit_q;
	assign remaining = remaining_q;
	assign empty_res = empty_q;

endmodule
